>>> rtl/dlsm_pkg.sv
`default_nettype none
package dlsm_pkg;

    localparam int EXPR_BYTES  = 256;
    localparam int STACK_DEPTH = 64;
    localparam int REG_COUNT   = 32;
    localparam int MAX_STEPS   = 4096;

    localparam int EA_W   = $clog2(EXPR_BYTES);
    localparam int PC_W   = $clog2(EXPR_BYTES + 1);
    localparam int SA_W   = $clog2(STACK_DEPTH);
    localparam int SP_W   = $clog2(STACK_DEPTH + 1);
    localparam int RF_W   = $clog2(REG_COUNT);
    localparam int STEP_W = $clog2(MAX_STEPS + 1);

    localparam logic [1:0] KIND_EXPR   = 2'd0;
    localparam logic [1:0] KIND_PRESET = 2'd1;
    localparam logic [1:0] KIND_REPLY  = 2'd2;

    localparam logic OUT_REQ   = 1'b0;
    localparam logic OUT_FINAL = 1'b1;

    localparam logic [1:0] LOC_MEM = 2'd0;
    localparam logic [1:0] LOC_REG = 2'd1;
    localparam logic [1:0] LOC_ERR = 2'd2;

    localparam logic [1:0] CFG_BASE    = 2'd0;
    localparam logic [1:0] CFG_FRAME   = 2'd1;
    localparam logic [1:0] CFG_PRESENT = 2'd2;

    localparam logic [31:0] SIZE_MASK1 = 32'h000000ff;
    localparam logic [31:0] SIZE_MASK2 = 32'h0000ffff;
    localparam logic [31:0] SIZE_MASK3 = 32'h00ffffff;

    localparam logic [7:0] OP_ADDR        = 8'h03;
    localparam logic [7:0] OP_DEREF       = 8'h06;
    localparam logic [7:0] OP_CONST1U     = 8'h08;
    localparam logic [7:0] OP_CONST1S     = 8'h09;
    localparam logic [7:0] OP_CONST2U     = 8'h0a;
    localparam logic [7:0] OP_CONST2S     = 8'h0b;
    localparam logic [7:0] OP_CONST4U     = 8'h0c;
    localparam logic [7:0] OP_CONST4S     = 8'h0d;
    localparam logic [7:0] OP_CONST8U     = 8'h0e;
    localparam logic [7:0] OP_CONST8S     = 8'h0f;
    localparam logic [7:0] OP_CONSTU      = 8'h10;
    localparam logic [7:0] OP_CONSTS      = 8'h11;
    localparam logic [7:0] OP_DUP         = 8'h12;
    localparam logic [7:0] OP_DROP        = 8'h13;
    localparam logic [7:0] OP_OVER        = 8'h14;
    localparam logic [7:0] OP_PICK        = 8'h15;
    localparam logic [7:0] OP_SWAP        = 8'h16;
    localparam logic [7:0] OP_ROT         = 8'h17;
    localparam logic [7:0] OP_XDEREF      = 8'h18;
    localparam logic [7:0] OP_ABS         = 8'h19;
    localparam logic [7:0] OP_AND         = 8'h1a;
    localparam logic [7:0] OP_DIV         = 8'h1b;
    localparam logic [7:0] OP_MINUS       = 8'h1c;
    localparam logic [7:0] OP_MOD         = 8'h1d;
    localparam logic [7:0] OP_MUL         = 8'h1e;
    localparam logic [7:0] OP_NEG         = 8'h1f;
    localparam logic [7:0] OP_NOT         = 8'h20;
    localparam logic [7:0] OP_OR          = 8'h21;
    localparam logic [7:0] OP_PLUS        = 8'h22;
    localparam logic [7:0] OP_PLUS_UCONST = 8'h23;
    localparam logic [7:0] OP_SHL         = 8'h24;
    localparam logic [7:0] OP_SHR         = 8'h25;
    localparam logic [7:0] OP_SHRA        = 8'h26;
    localparam logic [7:0] OP_XOR         = 8'h27;
    localparam logic [7:0] OP_BRA         = 8'h28;
    localparam logic [7:0] OP_EQ          = 8'h29;
    localparam logic [7:0] OP_GE          = 8'h2a;
    localparam logic [7:0] OP_GT          = 8'h2b;
    localparam logic [7:0] OP_LE          = 8'h2c;
    localparam logic [7:0] OP_LT          = 8'h2d;
    localparam logic [7:0] OP_NE          = 8'h2e;
    localparam logic [7:0] OP_SKIP        = 8'h2f;
    localparam logic [7:0] OP_LIT0        = 8'h30;
    localparam logic [7:0] OP_LIT31       = 8'h4f;
    localparam logic [7:0] OP_REG0        = 8'h50;
    localparam logic [7:0] OP_REG31       = 8'h6f;
    localparam logic [7:0] OP_BREG0       = 8'h70;
    localparam logic [7:0] OP_BREG31      = 8'h8f;
    localparam logic [7:0] OP_REGX        = 8'h90;
    localparam logic [7:0] OP_FBREG       = 8'h91;
    localparam logic [7:0] OP_BREGX       = 8'h92;
    localparam logic [7:0] OP_PIECE       = 8'h93;
    localparam logic [7:0] OP_DEREF_SIZE  = 8'h94;
    localparam logic [7:0] OP_XDEREF_SIZE = 8'h95;

    function automatic logic [31:0] alu(input logic [7:0] op, input logic [31:0] b,
                                        input logic [31:0] a);
        logic big;
        big = (a >= 32'd32);
        unique case (op)
            OP_AND:   alu = b & a;
            OP_MINUS: alu = b - a;
            OP_MUL:   alu = b * a;
            OP_OR:    alu = b | a;
            OP_PLUS:  alu = b + a;
            OP_SHL:   alu = big ? 32'd0 : b << a[4:0];
            OP_SHR:   alu = big ? 32'd0 : b >> a[4:0];
            OP_SHRA:  alu = $signed(b) >>> (big ? 5'd31 : a[4:0]);
            OP_XOR:   alu = b ^ a;
            OP_EQ:    alu = {31'd0, b == a};
            OP_GE:    alu = {31'd0, $signed(b) >= $signed(a)};
            OP_GT:    alu = {31'd0, $signed(b) > $signed(a)};
            OP_LE:    alu = {31'd0, $signed(b) <= $signed(a)};
            OP_LT:    alu = {31'd0, $signed(b) < $signed(a)};
            default:  alu = {31'd0, b != a};
        endcase
    endfunction

endpackage
`default_nettype wire

>>> rtl/dwarf_location_stack_machine_top.sv
// Expression bytes, register presets and memory replies are accepted only while idle.
// Evaluation uses registered reads of the expression and operand stack memories; div
// and mod step through a shift-and-subtract divider. One transaction is worked on at a
// time; a finished result waits in the output register. Synchronous active-low reset
// clears control state and the register file at once.
`default_nettype none
module dwarf_location_stack_machine_top
    import dlsm_pkg::*;
(
    input  wire         aclk,
    input  wire         aresetn,
    input  wire         s_valid,
    output logic        s_ready,
    input  wire  [1:0]  s_kind,
    input  wire  [7:0]  s_expr_byte,
    input  wire         s_last_byte,
    input  wire  [4:0]  s_reg_number,
    input  wire  [31:0] s_data_word,
    output logic        m_valid,
    input  wire         m_ready,
    output logic        m_out_kind,
    output logic [1:0]  m_location_kind,
    output logic [31:0] m_result_value,
    output logic [2:0]  m_read_size,
    input  wire         cfg_valid,
    output logic        cfg_ready,
    input  wire  [1:0]  cfg_index,
    input  wire  [31:0] cfg_data
);

    typedef enum logic [4:0] {
        S_IDLE, S_START, S_START_OP, S_RUN, S_DECODE, S_LE, S_LE_W, S_LEB, S_LEB_W,
        S_EXEC, S_PUSH, S_RD1, S_RD2, S_RD3, S_WR2, S_WR3, S_DIV, S_DIVW, S_FINAL,
        S_ERR, S_EMIT
    } state_t;

    state_t            state_reg;
    logic [31:0]       base_reg, fp_reg;
    logic              fpres_reg;
    logic [PC_W-1:0]   len_reg, pc_reg;
    logic [SP_W-1:0]   sp_reg;
    logic [STEP_W-1:0] step_reg;
    logic              await_reg;
    logic [2:0]        pend_reg;
    logic [7:0]        op_reg;
    logic [31:0]       v_reg, w_reg, a_reg, b_reg, pv_reg;
    logic [3:0]        cnt_reg, idx_reg;
    logic [5:0]        shift_reg;
    logic              sgn_reg, second_reg, regx_reg;
    logic [4:0]        div_cnt_reg;
    logic [32:0]       rem_reg;
    logic [31:0]       quo_reg;
    logic              e_kind_reg;
    logic [1:0]        e_loc_reg;
    logic [31:0]       e_val_reg;
    logic [2:0]        e_size_reg;
    logic              m_valid_reg, m_out_kind_reg;
    logic [1:0]        m_loc_reg;
    logic [31:0]       m_val_reg;
    logic [2:0]        m_size_reg;
    logic [31:0]       rf_reg [REG_COUNT];
    logic [7:0]        expr_mem [EXPR_BYTES];
    logic [31:0]       stk_mem [STACK_DEPTH];
    logic [7:0]        expr_q;
    logic [31:0]       stk_q;

    logic [SP_W-1:0]   sp_m1, sp_m2, sp_m3, pick_idx;
    logic [31:0]       rf_idx, rf_val, tgt, reply_mask, leb_v, alu_res;
    logic [5:0]        leb_shift;
    logic              byte_ok, jump_bad, div_ge;
    logic [32:0]       rem_sh;

    assign sp_m1    = sp_reg - SP_W'(1);
    assign sp_m2    = sp_reg - SP_W'(2);
    assign sp_m3    = sp_reg - SP_W'(3);
    assign pick_idx = sp_m1 - SP_W'(v_reg);
    assign byte_ok  = pc_reg < len_reg;
    assign rf_idx   = (op_reg == OP_BREGX) ? w_reg : 32'(op_reg - OP_BREG0);
    assign rf_val   = (rf_idx < 32'(REG_COUNT)) ? rf_reg[rf_idx[RF_W-1:0]] : 32'd0;
    assign tgt      = 32'(pc_reg) + {{16{v_reg[15]}}, v_reg[15:0]};
    assign jump_bad = tgt > 32'(len_reg);
    assign rem_sh   = {rem_reg[31:0], quo_reg[31]};
    assign div_ge   = rem_sh >= {1'b0, a_reg};
    assign alu_res  = alu(op_reg, stk_q, a_reg);

    assign leb_shift = (shift_reg < 6'd32) ? shift_reg + 6'd7 : shift_reg;
    assign leb_v     = (shift_reg < 6'd32) ?
                       (v_reg | (32'(expr_q[6:0]) << shift_reg[4:0])) : v_reg;

    always_comb begin
        unique case (pend_reg)
            3'd1:    reply_mask = SIZE_MASK1;
            3'd2:    reply_mask = SIZE_MASK2;
            3'd3:    reply_mask = SIZE_MASK3;
            default: reply_mask = '1;
        endcase
    end

    assign s_ready         = (state_reg == S_IDLE);
    assign cfg_ready       = 1'b1;
    assign m_valid         = m_valid_reg;
    assign m_out_kind      = m_out_kind_reg;
    assign m_location_kind = m_loc_reg;
    assign m_result_value  = m_val_reg;
    assign m_read_size     = m_size_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            base_reg    <= '0;
            fp_reg      <= '0;
            fpres_reg   <= 1'b1;
            len_reg     <= '0;
            pc_reg      <= '0;
            sp_reg      <= '0;
            step_reg    <= '0;
            await_reg   <= 1'b0;
            pend_reg    <= 3'd4;
            regx_reg    <= 1'b0;
            second_reg  <= 1'b0;
            m_valid_reg <= 1'b0;
            for (int i = 0; i < REG_COUNT; i++) begin
                rf_reg[i] <= '0;
            end
        end else begin
            if (cfg_valid) begin
                unique case (cfg_index)
                    CFG_BASE:    base_reg  <= cfg_data;
                    CFG_FRAME:   fp_reg    <= cfg_data;
                    CFG_PRESENT: fpres_reg <= cfg_data[0];
                    default: ;
                endcase
            end
            if (m_valid_reg && m_ready && state_reg != S_EMIT) begin
                m_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE: if (s_valid) begin
                    unique case (s_kind)
                        KIND_PRESET: if (32'(s_reg_number) < 32'(REG_COUNT)) begin
                            rf_reg[RF_W'(s_reg_number)] <= s_data_word;
                        end
                        KIND_EXPR: if (!await_reg) begin
                            if (len_reg < PC_W'(EXPR_BYTES)) begin
                                expr_mem[len_reg[EA_W-1:0]] <= s_expr_byte;
                                len_reg <= len_reg + PC_W'(1);
                            end
                            if (s_last_byte) begin
                                state_reg <= S_START;
                            end
                        end
                        KIND_REPLY: if (await_reg) begin
                            await_reg <= 1'b0;
                            if (sp_reg == '0) begin
                                state_reg <= S_ERR;
                            end else begin
                                stk_mem[sp_m1[SA_W-1:0]] <= s_data_word & reply_mask;
                                state_reg <= S_RUN;
                            end
                        end
                        default: ;
                    endcase
                end
                S_START: begin
                    expr_q    <= expr_mem[0];
                    pc_reg    <= PC_W'(1);
                    sp_reg    <= '0;
                    step_reg  <= '0;
                    await_reg <= 1'b0;
                    state_reg <= S_START_OP;
                end
                S_START_OP: begin
                    if (expr_q >= OP_REG0 && expr_q <= OP_REG31) begin
                        e_kind_reg <= OUT_FINAL;
                        e_loc_reg  <= LOC_REG;
                        e_val_reg  <= 32'(expr_q - OP_REG0);
                        e_size_reg <= '0;
                        state_reg  <= S_EMIT;
                    end else if (expr_q == OP_REGX) begin
                        op_reg    <= OP_REGX;
                        regx_reg  <= 1'b1;
                        sgn_reg   <= 1'b0;
                        v_reg     <= '0;
                        shift_reg <= '0;
                        state_reg <= S_LEB;
                    end else begin
                        stk_mem[0] <= base_reg;
                        sp_reg     <= SP_W'(1);
                        pc_reg     <= '0;
                        state_reg  <= S_RUN;
                    end
                end
                S_RUN: begin
                    if (!byte_ok) begin
                        if (sp_reg == '0) begin
                            state_reg <= S_ERR;
                        end else begin
                            stk_q     <= stk_mem[sp_m1[SA_W-1:0]];
                            state_reg <= S_FINAL;
                        end
                    end else if (step_reg >= STEP_W'(MAX_STEPS)) begin
                        state_reg <= S_ERR;
                    end else begin
                        step_reg  <= step_reg + STEP_W'(1);
                        expr_q    <= expr_mem[pc_reg[EA_W-1:0]];
                        pc_reg    <= pc_reg + PC_W'(1);
                        state_reg <= S_DECODE;
                    end
                end
                S_DECODE: begin
                    op_reg     <= expr_q;
                    v_reg      <= '0;
                    idx_reg    <= '0;
                    shift_reg  <= '0;
                    second_reg <= 1'b0;
                    regx_reg   <= 1'b0;
                    unique case (expr_q) inside
                        OP_CONST1U, OP_CONST1S, OP_PICK, OP_DEREF_SIZE: begin
                            cnt_reg   <= 4'd1;
                            state_reg <= S_LE;
                        end
                        OP_CONST2U, OP_CONST2S, OP_BRA, OP_SKIP: begin
                            cnt_reg   <= 4'd2;
                            state_reg <= S_LE;
                        end
                        OP_ADDR, OP_CONST4U, OP_CONST4S: begin
                            cnt_reg   <= 4'd4;
                            state_reg <= S_LE;
                        end
                        OP_CONST8U, OP_CONST8S: begin
                            cnt_reg   <= 4'd8;
                            state_reg <= S_LE;
                        end
                        OP_CONSTU, OP_PLUS_UCONST, OP_BREGX: begin
                            sgn_reg   <= 1'b0;
                            state_reg <= S_LEB;
                        end
                        OP_CONSTS, OP_FBREG, [OP_BREG0:OP_BREG31]: begin
                            sgn_reg   <= 1'b1;
                            state_reg <= S_LEB;
                        end
                        default: state_reg <= S_EXEC;
                    endcase
                end
                S_LE: begin
                    if (cnt_reg == '0) begin
                        state_reg <= S_EXEC;
                    end else if (!byte_ok) begin
                        state_reg <= S_ERR;
                    end else begin
                        expr_q    <= expr_mem[pc_reg[EA_W-1:0]];
                        pc_reg    <= pc_reg + PC_W'(1);
                        state_reg <= S_LE_W;
                    end
                end
                S_LE_W: begin
                    if (idx_reg < 4'd4) begin
                        v_reg <= v_reg | (32'(expr_q) << {idx_reg[1:0], 3'b000});
                    end
                    idx_reg   <= idx_reg + 4'd1;
                    cnt_reg   <= cnt_reg - 4'd1;
                    state_reg <= S_LE;
                end
                S_LEB: begin
                    if (!byte_ok) begin
                        state_reg <= S_ERR;
                    end else begin
                        expr_q    <= expr_mem[pc_reg[EA_W-1:0]];
                        pc_reg    <= pc_reg + PC_W'(1);
                        state_reg <= S_LEB_W;
                    end
                end
                S_LEB_W: begin
                    shift_reg <= leb_shift;
                    if (expr_q[7]) begin
                        v_reg     <= leb_v;
                        state_reg <= S_LEB;
                    end else begin
                        if (sgn_reg && leb_shift < 6'd32 && expr_q[6]) begin
                            v_reg <= leb_v | ('1 << leb_shift[4:0]);
                        end else begin
                            v_reg <= leb_v;
                        end
                        state_reg <= S_EXEC;
                    end
                end
                S_EXEC: begin
                    if (regx_reg) begin
                        e_kind_reg <= OUT_FINAL;
                        e_loc_reg  <= LOC_REG;
                        e_val_reg  <= v_reg;
                        e_size_reg <= '0;
                        state_reg  <= S_EMIT;
                    end else if (op_reg == OP_BREGX && !second_reg) begin
                        w_reg      <= v_reg;
                        v_reg      <= '0;
                        shift_reg  <= '0;
                        sgn_reg    <= 1'b1;
                        second_reg <= 1'b1;
                        state_reg  <= S_LEB;
                    end else begin
                        unique case (op_reg) inside
                            [OP_LIT0:OP_LIT31]: begin
                                pv_reg    <= 32'(op_reg - OP_LIT0);
                                state_reg <= S_PUSH;
                            end
                            [OP_BREG0:OP_BREG31], OP_BREGX: begin
                                pv_reg    <= rf_val + v_reg;
                                state_reg <= fpres_reg ? S_PUSH : S_ERR;
                            end
                            OP_FBREG: begin
                                pv_reg    <= ((base_reg == '0) ? fp_reg : base_reg) + v_reg;
                                state_reg <= fpres_reg ? S_PUSH : S_ERR;
                            end
                            OP_ADDR, OP_CONST1U, OP_CONST2U, OP_CONST4U, OP_CONST4S,
                            OP_CONST8U, OP_CONST8S, OP_CONSTU, OP_CONSTS: begin
                                pv_reg    <= v_reg;
                                state_reg <= S_PUSH;
                            end
                            OP_CONST1S: begin
                                pv_reg    <= {{24{v_reg[7]}}, v_reg[7:0]};
                                state_reg <= S_PUSH;
                            end
                            OP_CONST2S: begin
                                pv_reg    <= {{16{v_reg[15]}}, v_reg[15:0]};
                                state_reg <= S_PUSH;
                            end
                            OP_AND, OP_DIV, OP_MINUS, OP_MOD, OP_MUL, OP_OR, OP_PLUS,
                            OP_SHL, OP_SHR, OP_SHRA, OP_XOR, OP_EQ, OP_GE, OP_GT, OP_LE,
                            OP_LT, OP_NE, OP_SWAP: begin
                                stk_q     <= stk_mem[sp_m1[SA_W-1:0]];
                                state_reg <= (sp_reg < SP_W'(2)) ? S_ERR : S_RD1;
                            end
                            OP_ROT: begin
                                stk_q     <= stk_mem[sp_m1[SA_W-1:0]];
                                state_reg <= (sp_reg < SP_W'(3)) ? S_ERR : S_RD1;
                            end
                            OP_OVER: begin
                                stk_q     <= stk_mem[sp_m2[SA_W-1:0]];
                                state_reg <= (sp_reg < SP_W'(2)) ? S_ERR : S_RD1;
                            end
                            OP_DUP, OP_ABS, OP_NEG, OP_NOT, OP_PLUS_UCONST: begin
                                stk_q     <= stk_mem[sp_m1[SA_W-1:0]];
                                state_reg <= (sp_reg == '0) ? S_ERR : S_RD1;
                            end
                            OP_DEREF: begin
                                pend_reg  <= 3'd4;
                                stk_q     <= stk_mem[sp_m1[SA_W-1:0]];
                                state_reg <= (sp_reg == '0) ? S_ERR : S_RD1;
                            end
                            OP_DEREF_SIZE: begin
                                pend_reg <= v_reg[2:0];
                                stk_q    <= stk_mem[sp_m1[SA_W-1:0]];
                                if (sp_reg == '0 || v_reg == '0 || v_reg > 32'd4) begin
                                    state_reg <= S_ERR;
                                end else begin
                                    state_reg <= S_RD1;
                                end
                            end
                            OP_DROP: begin
                                if (sp_reg == '0) begin
                                    state_reg <= S_ERR;
                                end else begin
                                    sp_reg    <= sp_m1;
                                    state_reg <= S_RUN;
                                end
                            end
                            OP_PICK: begin
                                if (v_reg < 32'(sp_reg)) begin
                                    stk_q     <= stk_mem[pick_idx[SA_W-1:0]];
                                    state_reg <= S_RD1;
                                end else begin
                                    state_reg <= S_RUN;
                                end
                            end
                            OP_BRA: begin
                                if (sp_reg == '0) begin
                                    state_reg <= S_ERR;
                                end else begin
                                    stk_q     <= stk_mem[sp_m1[SA_W-1:0]];
                                    sp_reg    <= sp_m1;
                                    state_reg <= S_RD1;
                                end
                            end
                            OP_SKIP: begin
                                if (jump_bad) begin
                                    state_reg <= S_ERR;
                                end else begin
                                    pc_reg    <= tgt[PC_W-1:0];
                                    state_reg <= S_RUN;
                                end
                            end
                            OP_XDEREF, OP_PIECE, OP_XDEREF_SIZE: state_reg <= S_ERR;
                            default: state_reg <= S_RUN;
                        endcase
                    end
                end
                S_PUSH: begin
                    if (sp_reg >= SP_W'(STACK_DEPTH)) begin
                        state_reg <= S_ERR;
                    end else begin
                        stk_mem[sp_reg[SA_W-1:0]] <= pv_reg;
                        sp_reg    <= sp_reg + SP_W'(1);
                        state_reg <= S_RUN;
                    end
                end
                S_RD1: begin
                    unique case (op_reg)
                        OP_DUP, OP_OVER, OP_PICK: begin
                            pv_reg    <= stk_q;
                            state_reg <= S_PUSH;
                        end
                        OP_NOT: begin
                            stk_mem[sp_m1[SA_W-1:0]] <= ~stk_q;
                            state_reg <= S_RUN;
                        end
                        OP_NEG: begin
                            stk_mem[sp_m1[SA_W-1:0]] <= 32'd0 - stk_q;
                            state_reg <= S_RUN;
                        end
                        OP_ABS: begin
                            stk_mem[sp_m1[SA_W-1:0]] <= stk_q[31] ? 32'd0 - stk_q : stk_q;
                            state_reg <= S_RUN;
                        end
                        OP_PLUS_UCONST: begin
                            stk_mem[sp_m1[SA_W-1:0]] <= stk_q + v_reg;
                            state_reg <= S_RUN;
                        end
                        OP_BRA: begin
                            if (stk_q != '0 && jump_bad) begin
                                state_reg <= S_ERR;
                            end else begin
                                if (stk_q != '0) begin
                                    pc_reg <= tgt[PC_W-1:0];
                                end
                                state_reg <= S_RUN;
                            end
                        end
                        OP_DEREF, OP_DEREF_SIZE: begin
                            e_kind_reg <= OUT_REQ;
                            e_loc_reg  <= LOC_MEM;
                            e_val_reg  <= stk_q;
                            e_size_reg <= pend_reg;
                            await_reg  <= 1'b1;
                            state_reg  <= S_EMIT;
                        end
                        default: begin
                            a_reg     <= stk_q;
                            stk_q     <= stk_mem[sp_m2[SA_W-1:0]];
                            state_reg <= S_RD2;
                        end
                    endcase
                end
                S_RD2: begin
                    unique case (op_reg)
                        OP_SWAP: begin
                            stk_mem[sp_m1[SA_W-1:0]] <= stk_q;
                            state_reg <= S_WR2;
                        end
                        OP_ROT: begin
                            b_reg     <= stk_q;
                            stk_q     <= stk_mem[sp_m3[SA_W-1:0]];
                            state_reg <= S_RD3;
                        end
                        OP_DIV, OP_MOD: begin
                            rem_reg     <= '0;
                            quo_reg     <= stk_q;
                            div_cnt_reg <= '0;
                            state_reg   <= (a_reg == '0) ? S_ERR : S_DIV;
                        end
                        default: begin
                            stk_mem[sp_m2[SA_W-1:0]] <= alu_res;
                            sp_reg    <= sp_m1;
                            state_reg <= S_RUN;
                        end
                    endcase
                end
                S_RD3: begin
                    stk_mem[sp_m1[SA_W-1:0]] <= b_reg;
                    b_reg     <= stk_q;
                    state_reg <= S_WR2;
                end
                S_WR2: begin
                    if (op_reg == OP_ROT) begin
                        stk_mem[sp_m2[SA_W-1:0]] <= b_reg;
                        state_reg <= S_WR3;
                    end else begin
                        stk_mem[sp_m2[SA_W-1:0]] <= a_reg;
                        state_reg <= S_RUN;
                    end
                end
                S_WR3: begin
                    stk_mem[sp_m3[SA_W-1:0]] <= a_reg;
                    state_reg <= S_RUN;
                end
                S_DIV: begin
                    rem_reg     <= div_ge ? rem_sh - {1'b0, a_reg} : rem_sh;
                    quo_reg     <= {quo_reg[30:0], div_ge};
                    div_cnt_reg <= div_cnt_reg + 5'd1;
                    if (div_cnt_reg == 5'd31) begin
                        state_reg <= S_DIVW;
                    end
                end
                S_DIVW: begin
                    stk_mem[sp_m2[SA_W-1:0]] <= (op_reg == OP_DIV) ? quo_reg : rem_reg[31:0];
                    sp_reg    <= sp_m1;
                    state_reg <= S_RUN;
                end
                S_FINAL: begin
                    e_kind_reg <= OUT_FINAL;
                    e_loc_reg  <= LOC_MEM;
                    e_val_reg  <= stk_q;
                    e_size_reg <= '0;
                    state_reg  <= S_EMIT;
                end
                S_ERR: begin
                    e_kind_reg <= OUT_FINAL;
                    e_loc_reg  <= LOC_ERR;
                    e_val_reg  <= '0;
                    e_size_reg <= '0;
                    state_reg  <= S_EMIT;
                end
                S_EMIT: if (!m_valid_reg || m_ready) begin
                    m_valid_reg    <= 1'b1;
                    m_out_kind_reg <= e_kind_reg;
                    m_loc_reg      <= e_loc_reg;
                    m_val_reg      <= e_val_reg;
                    m_size_reg     <= e_size_reg;
                    if (e_kind_reg == OUT_FINAL) begin
                        len_reg   <= '0;
                        await_reg <= 1'b0;
                    end
                    state_reg <= S_IDLE;
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

`ifndef SYNTH
    a_sp_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        sp_reg <= SP_W'(STACK_DEPTH))
        else $error("operand stack count beyond depth");

    a_req_size: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && m_out_kind_reg == OUT_REQ) |-> (m_size_reg >= 3'd1 && m_size_reg <= 3'd4))
        else $error("read request with bad size");

    a_err_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && m_loc_reg == LOC_ERR) |-> (m_val_reg == '0 && m_size_reg == '0))
        else $error("error answer carries a value");

    a_req_await: assert property (@(posedge aclk) disable iff (!aresetn)
        ($rose(m_valid_reg) && m_out_kind_reg == OUT_REQ) |-> await_reg)
        else $error("read request issued without awaiting a reply");
`endif

endmodule
`default_nettype wire

>>> bench/dwarf_location_stack_machine_checker.sv
`timescale 1ns / 100ps
module dwarf_location_stack_machine_checker
    import dlsm_pkg::*;
(
    input  wire         aclk,
    input  wire         aresetn,
    input  wire         s_valid,
    input  wire         s_ready,
    input  wire  [1:0]  s_kind,
    input  wire  [7:0]  s_expr_byte,
    input  wire         s_last_byte,
    input  wire  [4:0]  s_reg_number,
    input  wire  [31:0] s_data_word,
    input  wire         m_valid,
    input  wire         m_ready,
    input  wire         m_out_kind,
    input  wire  [1:0]  m_location_kind,
    input  wire  [31:0] m_result_value,
    input  wire  [2:0]  m_read_size,
    input  wire         cfg_valid,
    input  wire         cfg_ready,
    input  wire  [1:0]  cfg_index,
    input  wire  [31:0] cfg_data,
    output int          mismatches,
    output int          answers_left
);

    typedef struct packed {
        logic        out_kind;
        logic [1:0]  loc_kind;
        logic [31:0] value;
        logic [2:0]  size;
    } answer_t;

    answer_t     answer_q[$];
    logic [7:0]  code[EXPR_BYTES];
    int unsigned code_len;
    logic [31:0] opstack[STACK_DEPTH];
    int unsigned depth;
    int unsigned pc;
    logic [31:0] regs[REG_COUNT];
    bit          waiting;
    int unsigned want_size;
    int unsigned steps;
    bit          bad;
    logic [31:0] base_addr;
    logic [31:0] frame_ptr;
    bit          has_frame;

    assign answers_left = answer_q.size();

    function automatic void answer(logic ok, logic [1:0] lk, logic [31:0] v, logic [2:0] sz);
        answer_t a;
        a.out_kind = ok;
        a.loc_kind = lk;
        a.value = v;
        a.size = sz;
        answer_q.push_back(a);
        if (ok) begin
            code_len = 0;
            waiting = 0;
        end
    endfunction

    function automatic logic [31:0] next_byte();
        if (pc >= code_len) begin
            bad = 1;
            return 32'd0;
        end
        pc++;
        return {24'd0, code[pc - 1]};
    endfunction

    function automatic logic [31:0] le_operand(int n);
        logic [31:0] v;
        logic [31:0] b;
        v = 0;
        for (int k = 0; k < n; k++) begin
            b = next_byte();
            if (k < 4) v |= b << (8 * k);
        end
        return v;
    endfunction

    function automatic logic [31:0] leb_operand(bit sgn);
        logic [31:0] v;
        logic [31:0] b;
        int unsigned sh;
        v = 0;
        sh = 0;
        do begin
            b = next_byte();
            if (bad) return 32'd0;
            if (sh < 32) begin
                v |= (b & 32'h7f) << sh;
                sh += 7;
            end
        end while (b[7]);
        if (sgn && sh < 32 && b[6]) v |= 32'hffffffff << sh;
        return v;
    endfunction

    function automatic void push(logic [31:0] v);
        if (depth >= STACK_DEPTH) begin
            bad = 1;
            return;
        end
        opstack[depth] = v;
        depth++;
    endfunction

    function automatic logic [31:0] pop();
        if (depth == 0) begin
            bad = 1;
            return 32'd0;
        end
        depth--;
        return opstack[depth];
    endfunction

    function automatic logic [31:0] reg_value(logic [31:0] n);
        return (n < REG_COUNT) ? regs[n] : 32'd0;
    endfunction

    function automatic void branch();
        logic [31:0] d;
        int t;
        d = le_operand(2);
        if (bad) return;
        t = int'(pc) + int'($signed(d[15:0]));
        if (t < 0 || t > int'(code_len)) bad = 1;
        else pc = t;
    endfunction

    function automatic logic [31:0] combine(logic [7:0] op, logic [31:0] b, logic [31:0] a);
        case (op)
            OP_AND:   return b & a;
            OP_DIV: begin
                if (a == 0) begin
                    bad = 1;
                    return 0;
                end
                return b / a;
            end
            OP_MINUS: return b - a;
            OP_MOD: begin
                if (a == 0) begin
                    bad = 1;
                    return 0;
                end
                return b % a;
            end
            OP_MUL:   return b * a;
            OP_OR:    return b | a;
            OP_PLUS:  return b + a;
            OP_SHL:   return (a >= 32) ? 32'd0 : b << a;
            OP_SHR:   return (a >= 32) ? 32'd0 : b >> a;
            OP_SHRA:  return (a >= 32) ? {32{b[31]}} : 32'($signed(b) >>> a);
            OP_XOR:   return b ^ a;
            OP_EQ:    return 32'(b == a);
            OP_GE:    return 32'($signed(b) >= $signed(a));
            OP_GT:    return 32'($signed(b) > $signed(a));
            OP_LE:    return 32'($signed(b) <= $signed(a));
            OP_LT:    return 32'($signed(b) < $signed(a));
            default:  return 32'(b != a);
        endcase
    endfunction

    function automatic void evaluate();
        logic [7:0] op;
        logic [31:0] v;
        logic [31:0] w;
        while (!bad) begin
            if (pc >= code_len) begin
                if (depth == 0) break;
                answer(OUT_FINAL, LOC_MEM, opstack[depth - 1], 3'd0);
                return;
            end
            if (steps >= MAX_STEPS) begin
                bad = 1;
                break;
            end
            steps++;
            op = code[pc];
            pc++;
            if (op >= OP_LIT0 && op <= OP_LIT31) begin
                push(32'(op - OP_LIT0));
            end else if (op >= OP_BREG0 && op <= OP_BREG31) begin
                v = leb_operand(1);
                if (!bad && !has_frame) bad = 1;
                if (!bad) push(reg_value(32'(op - OP_BREG0)) + v);
            end else if ((op >= OP_AND && op <= OP_MUL) || op == OP_OR || op == OP_PLUS ||
                         (op >= OP_SHL && op <= OP_XOR) || (op >= OP_EQ && op <= OP_NE)) begin
                v = pop();
                w = pop();
                if (!bad) begin
                    w = combine(op, w, v);
                    if (!bad) push(w);
                end
            end else begin
                case (op)
                    OP_ADDR, OP_CONST4U, OP_CONST4S: begin
                        v = le_operand(4);
                        if (!bad) push(v);
                    end
                    OP_CONST1U: begin
                        v = le_operand(1);
                        if (!bad) push(v);
                    end
                    OP_CONST1S: begin
                        v = le_operand(1);
                        if (!bad) push({{24{v[7]}}, v[7:0]});
                    end
                    OP_CONST2U: begin
                        v = le_operand(2);
                        if (!bad) push(v);
                    end
                    OP_CONST2S: begin
                        v = le_operand(2);
                        if (!bad) push({{16{v[15]}}, v[15:0]});
                    end
                    OP_CONST8U, OP_CONST8S: begin
                        v = le_operand(8);
                        if (!bad) push(v);
                    end
                    OP_CONSTU: begin
                        v = leb_operand(0);
                        if (!bad) push(v);
                    end
                    OP_CONSTS: begin
                        v = leb_operand(1);
                        if (!bad) push(v);
                    end
                    OP_DUP: begin
                        if (depth == 0) bad = 1;
                        else push(opstack[depth - 1]);
                    end
                    OP_DROP: v = pop();
                    OP_OVER: begin
                        if (depth < 2) bad = 1;
                        else push(opstack[depth - 2]);
                    end
                    OP_PICK: begin
                        v = le_operand(1);
                        if (!bad && v < depth) push(opstack[depth - 1 - v]);
                    end
                    OP_SWAP: begin
                        if (depth < 2) bad = 1;
                        else begin
                            v = opstack[depth - 1];
                            opstack[depth - 1] = opstack[depth - 2];
                            opstack[depth - 2] = v;
                        end
                    end
                    OP_ROT: begin
                        if (depth < 3) bad = 1;
                        else begin
                            v = opstack[depth - 1];
                            opstack[depth - 1] = opstack[depth - 2];
                            opstack[depth - 2] = opstack[depth - 3];
                            opstack[depth - 3] = v;
                        end
                    end
                    OP_ABS, OP_NEG, OP_NOT: begin
                        if (depth == 0) bad = 1;
                        else begin
                            v = opstack[depth - 1];
                            if (op == OP_NOT) v = ~v;
                            else if (op == OP_NEG || v[31]) v = -v;
                            opstack[depth - 1] = v;
                        end
                    end
                    OP_PLUS_UCONST: begin
                        v = leb_operand(0);
                        if (!bad && depth == 0) bad = 1;
                        if (!bad) opstack[depth - 1] += v;
                    end
                    OP_BRA: begin
                        v = le_operand(2);
                        if (!bad) begin
                            pc -= 2;
                            w = pop();
                            if (!bad) begin
                                if (w != 0) branch();
                                else pc += 2;
                            end
                        end
                    end
                    OP_SKIP: branch();
                    OP_FBREG: begin
                        v = leb_operand(1);
                        if (!bad && !has_frame) bad = 1;
                        if (!bad) push(((base_addr == 0) ? frame_ptr : base_addr) + v);
                    end
                    OP_BREGX: begin
                        w = leb_operand(0);
                        v = leb_operand(1);
                        if (!bad && !has_frame) bad = 1;
                        if (!bad) push(reg_value(w) + v);
                    end
                    OP_DEREF: begin
                        if (depth == 0) bad = 1;
                        else begin
                            want_size = 4;
                            waiting = 1;
                            answer(OUT_REQ, LOC_MEM, opstack[depth - 1], 3'd4);
                            return;
                        end
                    end
                    OP_DEREF_SIZE: begin
                        v = le_operand(1);
                        if (!bad) begin
                            if (depth == 0 || v < 1 || v > 4) bad = 1;
                            else begin
                                want_size = v;
                                waiting = 1;
                                answer(OUT_REQ, LOC_MEM, opstack[depth - 1], v[2:0]);
                                return;
                            end
                        end
                    end
                    OP_XDEREF, OP_PIECE, OP_XDEREF_SIZE: bad = 1;
                    default: ;
                endcase
            end
        end
        answer(OUT_FINAL, LOC_ERR, 32'd0, 3'd0);
    endfunction

    function automatic void begin_expr();
        logic [7:0] op;
        logic [31:0] v;
        pc = 0;
        depth = 0;
        steps = 0;
        waiting = 0;
        bad = 0;
        if (code_len == 0) begin
            answer(OUT_FINAL, LOC_ERR, 32'd0, 3'd0);
            return;
        end
        op = code[0];
        if (op >= OP_REG0 && op <= OP_REG31) begin
            answer(OUT_FINAL, LOC_REG, 32'(op - OP_REG0), 3'd0);
        end else if (op == OP_REGX) begin
            pc = 1;
            v = leb_operand(0);
            if (bad) answer(OUT_FINAL, LOC_ERR, 32'd0, 3'd0);
            else answer(OUT_FINAL, LOC_REG, v, 3'd0);
        end else begin
            push(base_addr);
            evaluate();
        end
    endfunction

    function automatic void take_item();
        logic [31:0] m;
        if (s_kind == KIND_PRESET) begin
            if (s_reg_number < REG_COUNT) regs[s_reg_number] = s_data_word;
        end else if (s_kind == KIND_EXPR) begin
            if (!waiting) begin
                if (code_len < EXPR_BYTES) begin
                    code[code_len] = s_expr_byte;
                    code_len++;
                end
                if (s_last_byte) begin_expr();
            end
        end else if (s_kind == KIND_REPLY && waiting) begin
            waiting = 0;
            bad = 0;
            case (want_size)
                1: m = SIZE_MASK1;
                2: m = SIZE_MASK2;
                3: m = SIZE_MASK3;
                default: m = 32'hffffffff;
            endcase
            if (depth == 0) answer(OUT_FINAL, LOC_ERR, 32'd0, 3'd0);
            else begin
                opstack[depth - 1] = s_data_word & m;
                evaluate();
            end
        end
    endfunction

    always @(posedge aclk) begin
        answer_t e;
        if (!aresetn) begin
            answer_q.delete();
            code_len = 0;
            depth = 0;
            pc = 0;
            foreach (regs[i]) regs[i] = 32'd0;
            waiting = 0;
            want_size = 4;
            steps = 0;
            bad = 0;
            base_addr = 0;
            frame_ptr = 0;
            has_frame = 1;
            mismatches = 0;
        end else begin
            if (m_valid && m_ready) begin
                if (answer_q.size() == 0) begin
                    $error("unexpected result transaction: value %0h", m_result_value);
                    mismatches++;
                end else begin
                    e = answer_q.pop_front();
                    if (m_out_kind !== e.out_kind) begin
                        $error("out_kind expected %0h actual %0h", e.out_kind, m_out_kind);
                        mismatches++;
                    end
                    if (m_location_kind !== e.loc_kind) begin
                        $error("location_kind expected %0h actual %0h", e.loc_kind,
                               m_location_kind);
                        mismatches++;
                    end
                    if (m_result_value !== e.value) begin
                        $error("result_value expected %0h actual %0h", e.value, m_result_value);
                        mismatches++;
                    end
                    if (m_read_size !== e.size) begin
                        $error("read_size expected %0h actual %0h", e.size, m_read_size);
                        mismatches++;
                    end
                end
            end
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    CFG_BASE:    base_addr = cfg_data;
                    CFG_FRAME:   frame_ptr = cfg_data;
                    CFG_PRESENT: has_frame = cfg_data[0];
                    default: ;
                endcase
            end
            if (s_valid && s_ready) take_item();
        end
    end

endmodule

>>> bench/dwarf_location_stack_machine_top_tb.sv
`timescale 1ns / 100ps
module dwarf_location_stack_machine_top_tb;
    import dlsm_pkg::*;

    localparam logic [1:0] KIND_UNUSED = 2'd3;
    localparam logic [7:0] OP_SPARE    = 8'h96;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [1:0]  s_kind = KIND_EXPR;
    logic [7:0]  s_expr_byte = 8'd0;
    logic        s_last_byte = 1'b0;
    logic [4:0]  s_reg_number = 5'd0;
    logic [31:0] s_data_word = 32'd0;
    logic        m_valid;
    logic        m_ready = 1'b1;
    logic        m_out_kind;
    logic [1:0]  m_location_kind;
    logic [31:0] m_result_value;
    logic [2:0]  m_read_size;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [1:0]  cfg_index = CFG_BASE;
    logic [31:0] cfg_data = 32'd0;

    int          mismatches;
    int          answers_left;
    int          results_seen = 0;
    logic        last_out_kind = OUT_FINAL;
    int          rx_mode = 0;
    int          rx_tick = 0;
    int          hold_left = 0;
    bit          hold_go = 0;
    bit          gaps_on = 0;
    int          burst_left = 0;
    int          items = 0;
    logic [7:0]  prog_q[$];

    always #10 aclk = ~aclk;

    dwarf_location_stack_machine_top u_top (.*);

    dwarf_location_stack_machine_checker u_checker (.*);

    always @(posedge aclk) begin
        if (m_valid && m_ready) begin
            results_seen <= results_seen + 1;
            last_out_kind <= m_out_kind;
        end
    end

    always @(negedge aclk) begin
        if (hold_go) begin
            hold_left = 400;
            hold_go = 0;
        end
        rx_tick++;
        if (hold_left > 0) begin
            hold_left--;
            m_ready <= 1'b0;
        end else begin
            case (rx_mode)
                0: m_ready <= 1'b1;
                1: m_ready <= $urandom_range(0, 1);
                default: m_ready <= (rx_tick % 11) < 6;
            endcase
        end
    end

    initial begin
        #(50_000_000);
        $display("tb: failure");
        $finish;
    end

    function automatic logic [31:0] rand_word();
        case ($urandom_range(0, 3))
            0: return 32'd0;
            1: return 32'hffffffff;
            default: return $urandom;
        endcase
    endfunction

    task automatic hush();
        @(negedge aclk);
        s_valid <= 1'b0;
    endtask

    task automatic send(logic [1:0] k, logic [7:0] b, logic l, logic [4:0] r, logic [31:0] d);
        bit took;
        if (gaps_on && burst_left == 0) begin
            repeat ($urandom_range(1, 6)) begin
                @(negedge aclk);
                s_valid <= 1'b0;
            end
            burst_left = $urandom_range(1, 12);
        end
        if (burst_left > 0) burst_left--;
        @(negedge aclk);
        s_valid <= 1'b1;
        s_kind <= k;
        s_expr_byte <= b;
        s_last_byte <= l;
        s_reg_number <= r;
        s_data_word <= d;
        took = 0;
        while (!took) begin
            #1;
            took = s_ready;
            @(posedge aclk);
            if (!took) @(negedge aclk);
        end
        items++;
    endtask

    task automatic preset(logic [4:0] r, logic [31:0] d);
        send(KIND_PRESET, $urandom, $urandom, r, d);
    endtask

    task automatic cfg_write(logic [1:0] idx, logic [31:0] d);
        bit took;
        hush();
        repeat (20) @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= d;
        took = 0;
        while (!took) begin
            #1;
            took = cfg_ready;
            @(posedge aclk);
            if (!took) @(negedge aclk);
        end
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    task automatic run_prog(int presets_after);
        int target;
        foreach (prog_q[i])
            send(KIND_EXPR, prog_q[i], i == prog_q.size() - 1, $urandom, $urandom);
        target = results_seen + 1;
        repeat (presets_after) preset($urandom, rand_word());
        forever begin
            hush();
            while (results_seen < target) @(negedge aclk);
            if (last_out_kind != OUT_REQ) break;
            if ($urandom_range(0, 3) == 0) send(KIND_EXPR, $urandom, $urandom, $urandom, $urandom);
            if ($urandom_range(0, 3) == 0) preset($urandom, rand_word());
            send(KIND_REPLY, $urandom, $urandom, $urandom, rand_word());
            target++;
        end
    endtask

    task automatic add_leb(logic [31:0] v, int n);
        for (int i = 0; i < n; i++) begin
            prog_q.push_back({i < n - 1, v[6:0]});
            v = v >> 7;
        end
    endtask

    task automatic add_lit(int k);
        prog_q.push_back(OP_LIT0 + 8'(k));
    endtask

    task automatic add_spares(int k);
        repeat (k) prog_q.push_back($urandom_range(OP_SPARE, 8'hff));
    endtask

    task automatic gen_expr();
        logic [7:0] consts[9] = '{OP_CONST1U, OP_CONST1S, OP_CONST2U, OP_CONST2S, OP_CONST4U,
                                  OP_CONST4S, OP_CONST8U, OP_CONST8S, OP_ADDR};
        int nbytes[9] = '{1, 1, 2, 2, 4, 4, 8, 8, 4};
        logic [7:0] binops[17] = '{OP_AND, OP_DIV, OP_MINUS, OP_MOD, OP_MUL, OP_OR, OP_PLUS,
                                   OP_SHL, OP_SHR, OP_SHRA, OP_XOR, OP_EQ, OP_GE, OP_GT,
                                   OP_LE, OP_LT, OP_NE};
        logic [7:0] op;
        int d;
        int r;
        int k;
        prog_q.delete();
        r = $urandom_range(0, 99);
        if (r < 5) begin
            prog_q.push_back(OP_REG0 + 8'($urandom_range(0, 31)));
            return;
        end
        if (r < 8) begin
            prog_q.push_back(OP_REGX);
            add_leb($urandom, $urandom_range(1, 6));
            return;
        end
        d = 1;
        repeat ($urandom_range(1, 14)) begin
            r = $urandom_range(0, 99);
            if (r < 30 && r >= 20) begin
                k = $urandom_range(0, 8);
                prog_q.push_back(consts[k]);
                repeat (nbytes[k]) prog_q.push_back($urandom);
                d++;
            end else if (r >= 30 && r < 35) begin
                prog_q.push_back($urandom_range(0, 1) ? OP_CONSTU : OP_CONSTS);
                add_leb(rand_word(), $urandom_range(1, 6));
                d++;
            end else if (r >= 35 && r < 40 && d >= 3) begin
                case ($urandom_range(0, 4))
                    0: begin prog_q.push_back(OP_DUP); d++; end
                    1: begin prog_q.push_back(OP_OVER); d++; end
                    2: begin
                        prog_q.push_back(OP_PICK);
                        prog_q.push_back($urandom_range(0, d + 1));
                        d++;
                    end
                    3: prog_q.push_back(OP_SWAP);
                    default: prog_q.push_back(OP_ROT);
                endcase
            end else if (r >= 40 && r < 52 && d >= 2) begin
                op = binops[$urandom_range(0, 16)];
                if ((op == OP_DIV || op == OP_MOD) && $urandom_range(0, 4) != 0) begin
                    add_lit($urandom_range(1, 31));
                    d++;
                end
                prog_q.push_back(op);
                d--;
            end else if (r >= 52 && r < 57) begin
                case ($urandom_range(0, 2))
                    0: prog_q.push_back(OP_ABS);
                    1: prog_q.push_back(OP_NEG);
                    default: prog_q.push_back(OP_NOT);
                endcase
            end else if (r >= 57 && r < 61) begin
                prog_q.push_back(OP_PLUS_UCONST);
                add_leb(rand_word(), $urandom_range(1, 5));
            end else if (r >= 61 && r < 67) begin
                case ($urandom_range(0, 2))
                    0: prog_q.push_back(OP_BREG0 + 8'($urandom_range(0, 31)));
                    1: begin
                        prog_q.push_back(OP_BREGX);
                        add_leb($urandom_range(0, 40), $urandom_range(1, 2));
                    end
                    default: prog_q.push_back(OP_FBREG);
                endcase
                add_leb(rand_word(), $urandom_range(1, 5));
                d++;
            end else if (r >= 67 && r < 71) begin
                if ($urandom_range(0, 1)) prog_q.push_back(OP_DEREF);
                else begin
                    prog_q.push_back(OP_DEREF_SIZE);
                    prog_q.push_back(($urandom_range(0, 9) == 0) ? $urandom : $urandom_range(1, 4));
                end
            end else if (r >= 71 && r < 79) begin
                k = $urandom_range(0, 3);
                if (r >= 75) add_lit($urandom_range(0, 1));
                prog_q.push_back((r >= 75) ? OP_BRA : OP_SKIP);
                if ($urandom_range(0, 19) == 0) begin
                    prog_q.push_back(8'h00);
                    prog_q.push_back(8'h80);
                end else begin
                    prog_q.push_back(k);
                    prog_q.push_back(8'h00);
                end
                add_spares(k);
            end else if (r >= 79 && r < 83) begin
                add_spares(1);
            end else if (r >= 83 && r < 87 && d >= 2) begin
                prog_q.push_back(OP_DROP);
                d--;
            end else if (r == 87) begin
                case ($urandom_range(0, 2))
                    0: prog_q.push_back(OP_XDEREF);
                    1: prog_q.push_back(OP_PIECE);
                    default: prog_q.push_back(OP_XDEREF_SIZE);
                endcase
            end else begin
                add_lit($urandom_range(0, 31));
                d++;
            end
        end
    endtask

    task automatic directed();
        preset(5'd0, 32'h0);
        preset(5'd31, 32'hffffffff);
        preset(5'd7, 32'h80000000);
        prog_q = '{OP_REG0};
        run_prog(0);
        prog_q = '{OP_REG31};
        run_prog(0);
        prog_q = '{OP_REGX, 8'hff, 8'hff, 8'hff, 8'hff, 8'h0f};
        run_prog(0);
        prog_q = '{OP_REGX, 8'h80};
        run_prog(0);
        prog_q = '{OP_BREG31, 8'h01, OP_DEREF};
        run_prog(0);
        prog_q = '{OP_LIT31, OP_DEREF_SIZE, 8'h01, OP_DEREF_SIZE, 8'h03};
        run_prog(0);
        prog_q = '{OP_DEREF_SIZE, 8'h00};
        run_prog(0);
        prog_q = '{OP_LIT0 + 8'd1, OP_LIT0, OP_DIV};
        run_prog(0);
        prog_q = '{OP_BREG0 + 8'd7, 8'h00, OP_LIT0 + 8'd20, OP_LIT0 + 8'd20, OP_PLUS, OP_SHRA,
                   OP_BREG0 + 8'd7, 8'h00, OP_ABS, OP_PLUS};
        run_prog(0);
        prog_q = '{OP_SKIP, 8'hfd, 8'hff};
        run_prog(0);
        prog_q = '{OP_DROP, OP_DROP};
        run_prog(0);
        prog_q = '{OP_DROP};
        run_prog(0);
        prog_q = '{OP_XDEREF};
        run_prog(0);
        prog_q = '{OP_PIECE};
        run_prog(0);
        prog_q = '{OP_FBREG, 8'h7f, OP_CONST8S, 8'h11, 8'h22, 8'h33, 8'h44, 8'h55, 8'h66,
                   8'h77, 8'h88, OP_CONST2U};
        run_prog(0);
        prog_q.delete();
        repeat (64) prog_q.push_back(OP_LIT0);
        run_prog(0);
        prog_q.delete();
        add_spares(258);
        prog_q.push_back(OP_LIT0 + 8'd5);
        run_prog(0);
    endtask

    initial begin
        logic [31:0] bases[6] = '{32'h0, 32'hffffffff, 32'h0, 32'h1000, 32'h0, 32'h80000000};
        logic [31:0] frames[6] = '{32'hffffffff, 32'h0, 32'h7ffffff0, 32'h0, 32'h12345678, 32'h0};
        bit presence[6] = '{1, 1, 0, 1, 1, 0};
        int goal;
        repeat (5) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        for (int p = 0; p < 6; p++) begin
            cfg_write(CFG_BASE, (p == 4) ? $urandom : bases[p]);
            cfg_write(CFG_FRAME, frames[p]);
            cfg_write(CFG_PRESENT, presence[p]);
            rx_mode = p % 3;
            gaps_on = (p % 2) == 1;
            if (p == 0) directed();
            if (p == 1) begin
                goal = results_seen + 2;
                hold_go = 1;
                send(KIND_EXPR, OP_LIT0 + 8'd5, 1'b1, 5'd0, 32'd0);
                prog_q = '{OP_LIT0 + 8'd3, OP_LIT0 + 8'd4, OP_PLUS};
                run_prog(16);
                while (results_seen < goal) @(negedge aclk);
            end
            goal = items + 100;
            while (items < goal) begin
                case ($urandom_range(0, 9))
                    0: repeat ($urandom_range(1, 3)) preset($urandom, rand_word());
                    1: send(($urandom_range(0, 1) ? KIND_REPLY : KIND_UNUSED), $urandom,
                            $urandom, $urandom, $urandom);
                    default: ;
                endcase
                gen_expr();
                run_prog(0);
            end
            hush();
        end
        repeat (200) @(negedge aclk);
        if (mismatches == 0 && answers_left == 0) $display("tb: success");
        else $display("tb: failure");
        $finish;
    end

endmodule
